/* src/online_softmax_weighted_sum_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the online softmax weighted-sum core
// Short forms for clocked concurrent assertions with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef ONLINE_SOFTMAX_WEIGHTED_SUM_CORE_MACROS_SVH
`define ONLINE_SOFTMAX_WEIGHTED_SUM_CORE_MACROS_SVH

// Assertion that is switched off while reset is held.
`define OSWS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is checked on every edge, reset included.
`define OSWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/osws_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osws_pkg
// Types, constants and the exponent table function shared by the core.
// ---------------------------------------------------------------------------
package osws_pkg;

  localparam int DATA_W = 16;
  localparam int EXP_W  = 17;
  localparam int SUM_W  = 25;
  localparam int ACC_W  = 41;
  localparam int NUM_W  = 42;
  localparam int DEN_W  = 26;
  localparam int CNT_W  = 6;

  localparam logic [EXP_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd42;

  // Unsigned long division by shift and subtract; elaboration only.
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    int              i;
    q = 0;
    r = 0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-l/256) in Q1.32 from a truncated Taylor series; elaboration only.
  function automatic logic [32:0] exp_frac_q32(input int unsigned l);
    longint          acc;
    longint unsigned t;
    int              k;
    acc = 64'sd1 <<< 32;
    t   = 64'd1 << 32;
    for (k = 1; k <= 24; k++) begin
      if (t != 0) begin
        t = div_u64(t * l, 64'(256 * k));
        if (k[0]) acc = acc - longint'(t);
        else      acc = acc + longint'(t);
      end
    end
    if (acc < 0) acc = 0;
    return acc[32:0];
  endfunction

  localparam logic [32:0] EXP_E1_Q32 = exp_frac_q32(256);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_PREP  = 8'b00000010,
    ST_EXP   = 8'b00000100,
    ST_MUL   = 8'b00001000,
    ST_UPD   = 8'b00010000,
    ST_DLOAD = 8'b00100000,
    ST_DIV   = 8'b01000000,
    ST_FIN   = 8'b10000000
  } state_t;

  typedef struct packed {
    logic load;
    logic exp_init;
    logic exp_step;
    logic exp_fin;
    logic mul;
    logic upd;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic exp_done;
    logic last;
    logic div_done;
  } status_t;

endpackage

/* src/online_softmax_weighted_sum_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// online_softmax_weighted_sum_core
// Streaming softmax-weighted average of Q8.8 values, one score/value word each.
// ---------------------------------------------------------------------------
// An ordinary word passes through the states PREP, EXP, MUL and UPD after
// acceptance before the next word can be taken. In EXP the exponent unit
// multiplies once by exp(-1) for each whole unit h (0 to 15) of the distance
// between the score and the running maximum, and one rescale multiply step
// follows in MUL. The first word of a run goes from PREP straight to UPD. A word
// marked last then loads and runs the serial divider, one quotient bit a cycle,
// and waits while an earlier result is still stalled in the output register;
// after that the result sits in the output register while the next run is taken.
module online_softmax_weighted_sum_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [osws_pkg::DATA_W-1:0] in_score,
  input  logic signed [osws_pkg::DATA_W-1:0] in_weight_value,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [osws_pkg::DATA_W-1:0] out_weighted_average
);

  osws_pkg::cmd_t    cmd;
  osws_pkg::status_t sts;

  osws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  osws_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_score             (in_score),
    .in_weight_value      (in_weight_value),
    .in_last              (in_last),
    .out_weighted_average (out_weighted_average)
  );

endmodule

/* src/osws_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osws_ctrl
// Sequencer for the update of one word and the final division of a run.
// ---------------------------------------------------------------------------
module osws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  osws_pkg::status_t sts,
  output osws_pkg::cmd_t    cmd
);

  osws_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_stall  = (state_r != osws_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      osws_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = osws_pkg::ST_PREP;
        end
      end
      osws_pkg::ST_PREP: begin
        cmd.exp_init = 1'b1;
        state_nxt    = sts.first ? osws_pkg::ST_UPD : osws_pkg::ST_EXP;
      end
      osws_pkg::ST_EXP: begin
        if (!sts.exp_done) begin
          cmd.exp_step = 1'b1;
        end else begin
          cmd.exp_fin = 1'b1;
          state_nxt   = osws_pkg::ST_MUL;
        end
      end
      osws_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = osws_pkg::ST_UPD;
      end
      osws_pkg::ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last ? osws_pkg::ST_DLOAD : osws_pkg::ST_IDLE;
      end
      osws_pkg::ST_DLOAD: begin
        // The divider is loaded once the sums of the last word have settled.
        cmd.div_init = 1'b1;
        state_nxt    = osws_pkg::ST_DIV;
      end
      osws_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = osws_pkg::ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      osws_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = osws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = osws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= osws_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/osws_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osws_dp
// Running maximum, exponent unit, rescale multipliers and serial divider.
// ---------------------------------------------------------------------------
module osws_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  osws_pkg::cmd_t                      cmd,
  output osws_pkg::status_t                   sts,
  input  logic signed [osws_pkg::DATA_W-1:0]  in_score,
  input  logic signed [osws_pkg::DATA_W-1:0]  in_weight_value,
  input  logic                                in_last,
  output logic signed [osws_pkg::DATA_W-1:0]  out_weighted_average
);

  logic [32:0] exp_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam logic [32:0] TabVal = osws_pkg::exp_frac_q32(i);
    assign exp_tab[i] = TabVal;
  end

  logic signed [osws_pkg::DATA_W-1:0] s_r, v_r, max_r;
  logic                               last_r;
  logic                               started_r;
  logic [osws_pkg::SUM_W-1:0]         sum_r;
  logic signed [osws_pkg::ACC_W-1:0]  acc_r;
  logic [3:0]                         h_r;
  logic [32:0]                        r_r;
  logic                               s_gt_r;
  logic [osws_pkg::EXP_W-1:0]         a_r, b_r;
  logic [41:0]                        psum_r;
  logic signed [58:0]                 pacc_r;
  logic signed [33:0]                 pbv_r;
  logic [osws_pkg::NUM_W-1:0]         num_r;
  logic [osws_pkg::DEN_W-1:0]         den_r;
  logic [osws_pkg::DEN_W-1:0]         rem_r;
  logic [osws_pkg::CNT_W-1:0]         cnt_r;
  logic                               neg_r, zero_r;
  logic signed [osws_pkg::DATA_W-1:0] res_r;

  logic signed [16:0]                 diff;
  logic                               s_gt;
  logic [16:0]                        d_mag;
  logic [65:0]                        eprod;
  logic [33:0]                        e_rnd;
  logic [osws_pkg::EXP_W-1:0]         e_val;
  logic [42:0]                        rsum;
  logic [27:0]                        sum_t;
  logic                               pacc_neg;
  logic [58:0]                        pacc_mag;
  logic [42:0]                        racc_mag;
  logic signed [44:0]                 acc_t;
  logic [osws_pkg::ACC_W-1:0]         acc_mag;
  logic [26:0]                        dv_t;
  logic                               dv_ge;
  logic [26:0]                        dv_sub;

  assign diff  = 17'(s_r) - 17'(max_r);
  assign s_gt  = (diff > 17'sd0);
  assign d_mag = s_gt ? diff : 17'(-diff);

  assign eprod = 66'(r_r) * 66'(osws_pkg::EXP_E1_Q32) + (66'd1 << 31);
  assign e_rnd = 34'(r_r) + 34'd32768;
  assign e_val = e_rnd[32:16];

  assign rsum  = 43'(psum_r) + 43'd32768;
  assign sum_t = 28'(rsum[42:16]) + 28'(b_r);

  // Products are rounded on their magnitude so that ties go away from zero.
  assign pacc_neg = pacc_r[58];
  assign pacc_mag = pacc_neg ? 59'(-pacc_r) : 59'(pacc_r);
  assign racc_mag = 43'(pacc_mag[58:16]) + 43'(pacc_mag[15]);
  assign acc_t    = (pacc_neg ? -$signed(45'(racc_mag)) : $signed(45'(racc_mag)))
                    + 45'(pbv_r);
  assign acc_mag  = acc_r[osws_pkg::ACC_W-1] ? osws_pkg::ACC_W'(-acc_r)
                                             : osws_pkg::ACC_W'(acc_r);

  assign dv_t   = {rem_r, num_r[osws_pkg::NUM_W-1]};
  assign dv_ge  = (dv_t >= {1'b0, den_r});
  assign dv_sub = dv_t - {1'b0, den_r};

  assign sts.first    = !started_r;
  assign sts.exp_done = (h_r == 4'd0);
  assign sts.last     = last_r;
  assign sts.div_done = (cnt_r == '0);

  assign out_weighted_average = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else if (cmd.div_init) begin
      started_r <= 1'b0;
    end else if (cmd.upd) begin
      started_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r    <= in_score;
      v_r    <= in_weight_value;
      last_r <= in_last;
    end
    if (cmd.exp_init) begin
      s_gt_r <= s_gt;
      // From sixteen whole units on, the weight is below the output precision.
      if (d_mag[16:12] != 5'd0) begin
        h_r <= 4'd0;
        r_r <= '0;
      end else begin
        h_r <= d_mag[11:8];
        r_r <= exp_tab[d_mag[7:0]];
      end
    end
    if (cmd.exp_step) begin
      r_r <= eprod[64:32];
      h_r <= h_r - 4'd1;
    end
    if (cmd.exp_fin) begin
      a_r <= s_gt_r ? e_val : osws_pkg::ONE_Q16;
      b_r <= s_gt_r ? osws_pkg::ONE_Q16 : e_val;
    end
    if (cmd.mul) begin
      psum_r <= 42'(sum_r) * 42'(a_r);
      pacc_r <= 59'(acc_r) * $signed(59'(a_r));
      pbv_r  <= $signed(34'(b_r)) * 34'(v_r);
    end
    if (cmd.upd) begin
      if (!started_r) begin
        max_r <= s_r;
        sum_r <= osws_pkg::SUM_W'(osws_pkg::ONE_Q16);
        acc_r <= osws_pkg::ACC_W'(v_r) <<< 16;
      end else begin
        max_r <= s_gt_r ? s_r : max_r;
        sum_r <= (sum_t > 28'(osws_pkg::SUM_MAX)) ? osws_pkg::SUM_MAX : sum_t[24:0];
        if (acc_t > 45'sd1099511627775)       acc_r <= 41'sh0FFFFFFFFFF;
        else if (acc_t < -45'sd1099511627776) acc_r <= 41'sh10000000000;
        else                                  acc_r <= acc_t[40:0];
      end
    end
    if (cmd.div_init) begin
      num_r  <= {acc_mag, 1'b0} + osws_pkg::NUM_W'(sum_r);
      den_r  <= {sum_r, 1'b0};
      rem_r  <= '0;
      cnt_r  <= osws_pkg::DIV_STEPS;
      neg_r  <= acc_r[osws_pkg::ACC_W-1];
      zero_r <= (sum_r == '0);
    end else if (cmd.div_step) begin
      rem_r <= dv_ge ? dv_sub[25:0] : dv_t[25:0];
      num_r <= {num_r[osws_pkg::NUM_W-2:0], dv_ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      if (zero_r) begin
        res_r <= '0;
      end else if (neg_r) begin
        res_r <= (num_r >= 42'd32768) ? 16'sh8000 : 16'(-num_r[15:0]);
      end else begin
        res_r <= (num_r > 42'd32767) ? 16'sh7FFF : num_r[15:0];
      end
    end
  end

endmodule

/* src/osws_chk.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osws_chk
// Port-level checks on the core's handshakes and sequencing.
// ---------------------------------------------------------------------------
`include "online_softmax_weighted_sum_core_macros.svh"

module osws_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic signed [osws_pkg::DATA_W-1:0] in_score,
  input logic signed [osws_pkg::DATA_W-1:0] in_weight_value,
  input logic                               in_last,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [osws_pkg::DATA_W-1:0] out_weighted_average
);

  // A stalled result word must be held unchanged.
  `OSWS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_weighted_average), "stalled result changed")

  // The core raises in_stall after each accepted word, so words are never taken back to back.
  `OSWS_ASSERT(a_in_busy, clk, rst_n, in_valid && !in_stall |=> in_stall, "word accepted back to back")

  // A new result only appears when the core was busy just before, never straight out of idle.
  `OSWS_ASSERT(a_out_src, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "result without finished run")

  // Reset leaves no result pending.
  `OSWS_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind online_softmax_weighted_sum_core osws_chk u_osws_chk (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Streams score/value runs through the softmax weighted-sum core and checks
// every averaged word against a cycle-free fixed-point predictor.
// ---------------------------------------------------------------------------
module tb_top;

  localparam longint SUM_LIM = (64'sd1 <<< 25) - 1;
  localparam longint ACC_HI  = (64'sd1 <<< 40) - 1;
  localparam longint ACC_LO  = -(64'sd1 <<< 40);
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [osws_pkg::DATA_W-1:0] in_score;
  logic signed [osws_pkg::DATA_W-1:0] in_weight_value;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic signed [osws_pkg::DATA_W-1:0] out_weighted_average;

  // Predictor state for the run in progress.
  longint run_max;
  longint run_sum;
  longint run_acc;
  bit     run_open;

  logic signed [osws_pkg::DATA_W-1:0] avg_queue[$];
  int     err_count = 0;
  longint cycle_count = 0;
  int     stall_mode = 0;

  online_softmax_weighted_sum_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_score(in_score), .in_weight_value(in_weight_value), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_weighted_average(out_weighted_average)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned taylor_q32(longint unsigned l);
    longint acc;
    longint unsigned t;
    acc = 64'sd1 <<< 32;
    t = 64'd1 << 32;
    for (int k = 1; k <= 24; k++) begin
      if (t != 0) begin
        t = (t * l) / (256 * k);
        if (k % 2 == 1) acc = acc - longint'(t);
        else acc = acc + longint'(t);
      end
    end
    if (acc < 0) acc = 0;
    return longint'(acc);
  endfunction

  function automatic longint decay_q16(longint d);
    longint unsigned r;
    longint unsigned e1;
    if ((d >> 8) >= 16) return 0;
    r = taylor_q32(d & 255);
    e1 = taylor_q32(256);
    for (int i = 0; i < (d >> 8); i++) r = (r * e1 + (64'd1 << 31)) >> 32;
    return longint'((r + (64'd1 << 15)) >> 16);
  endfunction

  function automatic longint round16(longint v);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Folds one accepted word into the running sums; queues the average on last.
  task automatic fold_word(input longint s, input longint v, input bit lst);
    longint nm, a, b, q, mag;
    if (!run_open) begin
      run_max = s;
      run_sum = 65536;
      run_acc = clip(65536 * v, ACC_LO, ACC_HI);
      run_open = 1;
    end else begin
      nm = s > run_max ? s : run_max;
      a = decay_q16(nm - run_max);
      b = decay_q16(nm - s);
      run_sum = clip(round16(run_sum * a) + b, 0, SUM_LIM);
      run_acc = clip(round16(run_acc * a) + b * v, ACC_LO, ACC_HI);
      run_max = nm;
    end
    if (lst) begin
      q = 0;
      if (run_sum > 0) begin
        mag = run_acc < 0 ? -run_acc : run_acc;
        q = (2 * mag + run_sum) / (2 * run_sum);
        if (run_acc < 0) q = -q;
      end
      avg_queue.push_back(osws_pkg::DATA_W'(clip(q, -32768, 32767)));
      run_open = 0;
      run_max = 0; run_sum = 0; run_acc = 0;
    end
  endtask

  // Sends one word, with a random gap first when a burst has ended.
  int burst_left;
  task automatic send_word(input logic signed [15:0] s, input logic signed [15:0] v,
                           input bit lst);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_score <= s;
    in_weight_value <= v;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
    fold_word(s, v, lst);
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
  endtask

  // Receiver stall pattern: switches among none, sparse, heavy and periodic.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= cycle_count[3];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (avg_queue.size() == 0) begin
        $display("%0t: unexpected word, actual %0d", $time, out_weighted_average);
        err_count++;
      end else begin
        if (out_weighted_average !== avg_queue[0]) begin
          $display("%0t: weighted_average expected %0d actual %0d", $time,
                   avg_queue[0], out_weighted_average);
          err_count++;
        end
        void'(avg_queue.pop_front());
      end
    end
  end

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  task automatic test_edge_fields();
    send_word(16'sh7FFF, 16'sh7FFF, 1);
    send_word(16'sh8000, 16'sh8000, 1);
    send_word(16'sh0000, 16'sh0000, 1);
    send_word(16'sh8000, 16'sh7FFF, 0);
    send_word(16'sh7FFF, 16'sh8000, 1);
    send_word(16'sh7FFF, 16'sh1234, 0);
    send_word(16'sh8000, 16'shFFFF, 1);
    send_word(16'sh0100, 16'sh0200, 0);
    send_word(16'sh0100, 16'shFE00, 0);
    send_word(16'sh0100, 16'sh0300, 1);
    for (int i = 0; i < 15; i++) send_word(16'(i * 64), 16'sh5555 ^ 16'(i), i == 14);
  endtask

  task automatic test_saturation();
    // Equal scores keep every weight at one, so the sums pile up past their range.
    for (int i = 0; i < 600; i++) send_word(16'sh0000, 16'sh7FFF, i == 599);
  endtask

  task automatic test_random_runs();
    int sent, len, spread;
    logic signed [15:0] base;
    sent = 0;
    while (sent < 725) begin
      len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 80) : $urandom_range(1, 12);
      spread = $urandom_range(0, 3);
      base = rnd16();
      for (int i = 0; i < len; i++) begin
        case (spread)
          0: send_word(rnd16(), rnd16(), i == len - 1);
          1: send_word(base + 16'($urandom_range(0, 1023)) - 16'sd512, rnd16(), i == len - 1);
          2: send_word(base + 16'($urandom_range(0, 4095)), rnd16(), i == len - 1);
          default: send_word(base ^ 16'($urandom_range(0, 255)), rnd16(), i == len - 1);
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_score = '0;
    in_weight_value = '0;
    in_last = 1'b0;
    run_open = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_fields();
    test_saturation();
    test_random_runs();
    end_stream();
    wait (avg_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
